@@ src/u8sd_pkg.sv @@
// u8sd_pkg: byte patterns, field widths and the per-byte decode step
// shared by the UTF-8 stream decoder. No dependencies.

package u8sd_pkg;

  // Field widths
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CodeW    = 21;
  localparam int unsigned PartialW = 15;  // widest open partial: 3 + 6 + 6 bits
  localparam int unsigned PendW    = 2;

  // Byte patterns: mask and match for each lead and the continuation form
  localparam logic [ByteW-1:0] AsciiMask = 8'h80;
  localparam logic [ByteW-1:0] ContMask  = 8'hc0;
  localparam logic [ByteW-1:0] ContCode  = 8'h80;
  localparam logic [ByteW-1:0] Lead2Mask = 8'he0;
  localparam logic [ByteW-1:0] Lead2Code = 8'hc0;
  localparam logic [ByteW-1:0] Lead3Mask = 8'hf0;
  localparam logic [ByteW-1:0] Lead3Code = 8'he0;
  localparam logic [ByteW-1:0] Lead4Mask = 8'hf8;
  localparam logic [ByteW-1:0] Lead4Code = 8'hf0;

  // Payload masks
  localparam logic [ByteW-1:0] Lead2Bits = 8'h1f;
  localparam logic [ByteW-1:0] Lead3Bits = 8'h0f;
  localparam logic [ByteW-1:0] Lead4Bits = 8'h07;
  localparam logic [ByteW-1:0] ContBits  = 8'h3f;

  // Continuation counts opened by each lead
  localparam logic [PendW-1:0] PendNone  = 2'd0;
  localparam logic [PendW-1:0] PendLead2 = 2'd1;
  localparam logic [PendW-1:0] PendLead3 = 2'd2;
  localparam logic [PendW-1:0] PendLead4 = 2'd3;

  // Decoder state carried from byte to byte
  typedef struct packed {
    logic [PartialW-1:0] partial;
    logic [PendW-1:0]    pending;
  } dec_state_t;

  // One result item
  typedef struct packed {
    logic             has_cp;
    logic [CodeW-1:0] cp;
    logic             is_end;
  } dec_result_t;

  // Decode one byte against the current state
  function automatic void decode_byte(
    input  dec_state_t  cur,
    input  logic [ByteW-1:0] b,
    input  logic        last,
    output dec_state_t  nxt,
    output dec_result_t res
  );
    logic [CodeW-1:0] grown;
    logic [PendW-1:0] left;
    grown      = {cur.partial, b[5:0]};
    left       = cur.pending - PendW'(1);
    nxt        = '0;
    res        = '0;
    res.is_end = last;
    if ((cur.pending != PendNone) && ((b & ContMask) == ContCode)) begin
      // Append six bits; report when the last continuation arrives
      if (left == PendNone) begin
        res.has_cp = 1'b1;
        res.cp     = grown;
      end else begin
        nxt.partial = grown[PartialW-1:0];
        nxt.pending = left;
      end
    end else if ((b & AsciiMask) == '0) begin
      res.has_cp = 1'b1;
      res.cp     = CodeW'(b);
    end else if ((b & Lead2Mask) == Lead2Code) begin
      nxt.partial = PartialW'(b & Lead2Bits);
      nxt.pending = PendLead2;
    end else if ((b & Lead3Mask) == Lead3Code) begin
      nxt.partial = PartialW'(b & Lead3Bits);
      nxt.pending = PendLead3;
    end else if ((b & Lead4Mask) == Lead4Code) begin
      nxt.partial = PartialW'(b & Lead4Bits);
      nxt.pending = PendLead4;
    end
    // Stray continuation or 11111xxx: skip, state already cleared
    if (last) begin
      nxt = '0;
    end
  endfunction

endpackage

@@ src/utf8_stream_decoder.sv @@
// utf8_stream_decoder: byte-at-a-time UTF-8 decoder with a registered result.
// Depends on u8sd_pkg for byte patterns, types and the decode step.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one raw byte and a flag
//   that marks the last byte of a buffer. Output channel (out_valid_o /
//   out_ready_i) carries exactly one result per byte: has_code_point_o,
//   code_point_o (zero unless has_code_point_o) and is_end_o.
//   Latency: the result for a byte is offered the cycle after its transfer.
//   Throughput: one byte per cycle unless stalled; the decode is a single
//   pass of masking and shifting between decoder state and result register.
//   A byte that completes a 1- to 4-byte sequence reports the code point.
//   Stray bytes are skipped, a sequence cut short is dropped and the
//   interrupting byte decodes as a new lead, and a sequence still open
//   after a buffer's last byte is dropped.
//   Reset clears the open sequence and empties the result register.
//   While the receiver stalls, the result holds and in_ready_o stays low
//   until that result is taken; a byte may transfer in the same cycle.

module utf8_stream_decoder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [u8sd_pkg::ByteW-1:0]  in_byte_i,
  input  logic                        buffer_end_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        has_code_point_o,
  output logic [u8sd_pkg::CodeW-1:0]  code_point_o,
  output logic                        is_end_o
);
  import u8sd_pkg::*;

  dec_state_t  state_q, state_d;
  dec_result_t res_q, res_d;
  logic        out_valid_q;
  logic        in_xfer;

  // Accept a byte whenever the result register is empty or being drained
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  // Decode the incoming byte against the open sequence
  always_comb begin
    decode_byte(state_q, in_byte_i, buffer_end_i, state_d, res_d);
  end

  // Advance decoder state on each transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_xfer) begin
      state_q <= state_d;
    end
  end

  // Track result occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Load the result payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign has_code_point_o = res_q.has_cp;
  assign code_point_o     = res_q.cp;
  assign is_end_o         = res_q.is_end;

`ifndef ASSERT_OFF
  // No partial bits may linger without an open sequence
  a_idle_partial_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.pending == PendNone) |-> (state_q.partial == '0))
    else $error("partial value held with no sequence open");

  // A buffer's last byte always closes any open sequence
  a_end_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && buffer_end_i) |=> (state_q.pending == PendNone))
    else $error("sequence left open after buffer end");

  // Code point field is zero on results without a code point
  a_cp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !has_code_point_o) |-> (code_point_o == '0))
    else $error("nonzero code point without valid flag");

  // Every transferred byte yields a result next cycle
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> out_valid_o)
    else $error("transferred byte produced no result");

  // An empty result register never blocks the input
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");
`endif

endmodule

@@ sim/utf8_decode_checker.sv @@
// utf8_decode_checker: watches both channels of the UTF-8 stream decoder,
// predicts one result per byte transfer and compares it with the output.
// Standalone; needs only the decoder's field widths.

module utf8_decode_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  in_byte_i,
  input  logic        buffer_end_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        has_code_point_i,
  input  logic [20:0] code_point_i,
  input  logic        is_end_i,
  output logic [31:0] fail_count_o,
  output logic [31:0] outstanding_o
);

  // Byte classes: mask and match
  localparam logic [7:0] HiBit      = 8'h80;
  localparam logic [7:0] ContMask   = 8'hc0;
  localparam logic [7:0] ContMatch  = 8'h80;
  localparam logic [7:0] Two4Mask   = 8'he0;
  localparam logic [7:0] Two4Match  = 8'hc0;
  localparam logic [7:0] ThreeMask  = 8'hf0;
  localparam logic [7:0] ThreeMatch = 8'he0;
  localparam logic [7:0] FourMask   = 8'hf8;
  localparam logic [7:0] FourMatch  = 8'hf0;

  typedef struct packed {
    logic        has_cp;
    logic [20:0] cp;
    logic        is_end;
  } cp_result_t;

  cp_result_t  expected_results[$];
  cp_result_t  got;
  cp_result_t  want;
  cp_result_t  predicted;
  logic [20:0] seq_bits;
  logic [1:0]  cont_left;
  int unsigned fail_count;

  assign fail_count_o = fail_count;

  // Advance the decode state by one byte and return the result it reports
  function automatic cp_result_t decode_next(input logic [7:0] b, input logic last);
    cp_result_t res;
    res = '0;
    res.is_end = last;
    if (cont_left != 2'd0 && (b & ContMask) == ContMatch) begin
      seq_bits  = {seq_bits[14:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left == 2'd0) begin
        res.has_cp = 1'b1;
        res.cp     = seq_bits;
        seq_bits   = '0;
      end
    end else begin
      // Any open sequence is dropped; decode the byte as a lead
      seq_bits  = '0;
      cont_left = 2'd0;
      if ((b & HiBit) == 8'h00) begin
        res.has_cp = 1'b1;
        res.cp     = {13'd0, b};
      end else if ((b & Two4Mask) == Two4Match) begin
        seq_bits  = {16'd0, b[4:0]};
        cont_left = 2'd1;
      end else if ((b & ThreeMask) == ThreeMatch) begin
        seq_bits  = {17'd0, b[3:0]};
        cont_left = 2'd2;
      end else if ((b & FourMask) == FourMatch) begin
        seq_bits  = {18'd0, b[2:0]};
        cont_left = 2'd3;
      end
    end
    // Drop whatever is still open at the buffer's last byte
    if (last) begin
      seq_bits  = '0;
      cont_left = 2'd0;
    end
    return res;
  endfunction

  // Check the output transfer first, then predict for the input transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_results.delete();
      seq_bits   = '0;
      cont_left  = 2'd0;
      fail_count = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got.has_cp = has_code_point_i;
        got.cp     = code_point_i;
        got.is_end = is_end_i;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: has=%0b cp=%06h end=%0b",
                   $time, got.has_cp, got.cp, got.is_end);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.has_cp !== want.has_cp || got.cp !== want.cp ||
              got.is_end !== want.is_end) begin
            $display("%0t: result mismatch: expected has=%0b cp=%06h end=%0b,",
                     $time, want.has_cp, want.cp, want.is_end,
                     " actual has=%0b cp=%06h end=%0b",
                     got.has_cp, got.cp, got.is_end);
            fail_count++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        predicted        = decode_next(in_byte_i, buffer_end_i);
        expected_results = {expected_results, predicted};
      end
    end
    outstanding_o = 32'(expected_results.size());
  end

endmodule

@@ sim/testbench.sv @@
// testbench: drives bytes into utf8_stream_decoder with random idling on
// both channels and gives the verdict. Depends on u8sd_pkg, the decoder
// and utf8_decode_checker.

module testbench;

  localparam int unsigned ByteTarget = 1800;
  localparam int unsigned QuietFrom  = 1600;
  localparam int unsigned IdleLimit  = 500;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        buffer_end;
  logic        out_valid;
  logic        out_ready;
  logic        has_code_point;
  logic [20:0] code_point;
  logic        is_end;
  logic [31:0] fail_count;
  logic [31:0] outstanding;

  int unsigned bytes_sent;
  int unsigned stall_left;
  int unsigned idle_cycles;
  bit          quiet;

  utf8_stream_decoder u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .in_byte_i       (in_byte),
    .buffer_end_i    (buffer_end),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .has_code_point_o(has_code_point),
    .code_point_o    (code_point),
    .is_end_o        (is_end)
  );

  utf8_decode_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .in_byte_i       (in_byte),
    .buffer_end_i    (buffer_end),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .has_code_point_i(has_code_point),
    .code_point_i    (code_point),
    .is_end_i        (is_end),
    .fail_count_o    (fail_count),
    .outstanding_o   (outstanding)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Stall the result side in random bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 14);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Count cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < IdleLimit) @(posedge clk);
    $display("testbench NOT OK");
    $finish;
  end

  // Offer one byte, with an optional idle burst before it, and hold it until it transfers
  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 15);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_byte    <= b;
    buffer_end <= last;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    bytes_sent++;
  endtask

  // Mostly well-formed sequences; some cut short, some raw noise bytes
  task automatic send_random_sequence();
    logic [7:0]  seq[4];
    int unsigned kind;
    int unsigned len;
    int unsigned count;
    kind = $urandom_range(0, 99);
    len  = $urandom_range(1, 4);
    for (int i = 1; i < 4; i++) seq[i] = {2'b10, 6'($urandom_range(0, 63))};
    case (len)
      1: seq[0] = {1'b0, 7'($urandom_range(0, 127))};
      2: seq[0] = {3'b110, 5'($urandom_range(0, 31))};
      3: seq[0] = {4'b1110, 4'($urandom_range(0, 15))};
      default: seq[0] = {5'b11110, 3'($urandom_range(0, 7))};
    endcase
    if (kind < 80) begin
      count = len;
    end else if (kind < 90 && len > 1) begin
      count = $urandom_range(1, len - 1);
    end else begin
      seq[0] = 8'($urandom_range(0, 255));
      count  = 1;
    end
    for (int i = 0; i < count; i++) begin
      send_byte(seq[i], $urandom_range(0, 19) == 0);
    end
  endtask

  initial begin
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_byte    <= 8'h00;
    buffer_end <= 1'b0;
    stall_left  = 0;
    idle_cycles = 0;
    bytes_sent  = 0;
    quiet       = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ASCII extremes, then multi-byte sequences, with the widest 2- and 4-byte leads
    send_byte(8'h00, 1'b0);
    send_byte(8'h7f, 1'b1);
    send_byte(8'hc2, 1'b0);
    send_byte(8'ha9, 1'b0);
    send_byte(8'hdf, 1'b0);
    send_byte(8'hbf, 1'b0);
    send_byte(8'he2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hac, 1'b0);
    send_byte(8'hf0, 1'b0);
    send_byte(8'h9f, 1'b0);
    send_byte(8'h98, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hf7, 1'b0);
    send_byte(8'hbf, 1'b0);
    send_byte(8'hbf, 1'b0);
    send_byte(8'hbf, 1'b1);
    // Stray continuation and bytes that fit no lead
    send_byte(8'h80, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hf8, 1'b0);
    // Sequence interrupted by a new lead
    send_byte(8'he2, 1'b0);
    send_byte(8'h41, 1'b0);
    // Sequence still open at the buffer's last byte
    send_byte(8'he2, 1'b0);
    send_byte(8'h82, 1'b1);
    send_byte(8'hac, 1'b0);

    while (bytes_sent < ByteTarget) begin
      if (bytes_sent >= QuietFrom) quiet = 1'b1;
      send_random_sequence();
    end
    in_valid <= 1'b0;

    // Drain, then allow the registered result to settle
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/u8sd_pkg.sv
src/utf8_stream_decoder.sv
sim/utf8_decode_checker.sv
sim/testbench.sv
